// ===== design/vsrl_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector slew rate limiter package
// Shared constants, microcode word layout and the control program table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vsrl_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int GUARD_BITS     = 8;
	localparam int LIMIT_RESET    = 8192;
	localparam int STEP_W         = 4;

	typedef logic [STEP_W-1:0] step_t;

	// datapath operation of one program step
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_DIFF,
		OP_SQUARE,
		OP_CMP,
		OP_ROOT,
		OP_PROD,
		OP_DIV,
		OP_MOVE,
		OP_PASS
	} op_t;

	// sequencing of one program step
	typedef enum logic [2:0] {
		JC_NONE,
		JC_WAIT,
		JC_SKIP_CLEAR,
		JC_LOOP,
		JC_END
	} jc_t;

	// loop counter preload
	typedef enum logic [1:0] {
		LC_NONE,
		LC_ROOT,
		LC_DIV
	} lc_t;

	typedef struct packed {
		op_t   op;
		jc_t   jc;
		lc_t   lc;
		step_t target;
	} ucode_t;

	typedef struct packed {
		op_t  op;
		logic commit;
	} ctrl_t;

	typedef struct packed {
		logic limited;
	} status_t;

	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_DIFF   = 4'd1;
	localparam step_t ST_SQUARE = 4'd2;
	localparam step_t ST_CMP    = 4'd3;
	localparam step_t ST_ROOT   = 4'd4;
	localparam step_t ST_PROD   = 4'd5;
	localparam step_t ST_DIV    = 4'd6;
	localparam step_t ST_MOVE   = 4'd7;
	localparam step_t ST_PASS   = 4'd8;

	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		w = '{op: OP_IDLE, jc: JC_WAIT, lc: LC_NONE, target: ST_IDLE};
		unique case (s)
			ST_IDLE:   w = '{op: OP_IDLE,   jc: JC_WAIT,       lc: LC_NONE, target: ST_IDLE};
			ST_DIFF:   w = '{op: OP_DIFF,   jc: JC_NONE,       lc: LC_NONE, target: ST_IDLE};
			ST_SQUARE: w = '{op: OP_SQUARE, jc: JC_NONE,       lc: LC_NONE, target: ST_IDLE};
			ST_CMP:    w = '{op: OP_CMP,    jc: JC_SKIP_CLEAR, lc: LC_ROOT, target: ST_PASS};
			ST_ROOT:   w = '{op: OP_ROOT,   jc: JC_LOOP,       lc: LC_NONE, target: ST_IDLE};
			ST_PROD:   w = '{op: OP_PROD,   jc: JC_NONE,       lc: LC_DIV,  target: ST_IDLE};
			ST_DIV:    w = '{op: OP_DIV,    jc: JC_LOOP,       lc: LC_NONE, target: ST_IDLE};
			ST_MOVE:   w = '{op: OP_MOVE,   jc: JC_END,        lc: LC_NONE, target: ST_IDLE};
			ST_PASS:   w = '{op: OP_PASS,   jc: JC_END,        lc: LC_NONE, target: ST_IDLE};
			default:   w = '{op: OP_IDLE,   jc: JC_END,        lc: LC_NONE, target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== design/vsrl_seq.sv =====
// ----------------------------------------------------------------------------
// Vector slew rate limiter sequencer
// Step counter, loop counter and program table lookup driving the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsrl_seq #(
	parameter int DATA_WIDTH = vsrl_pkg::DATA_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              out_free,
	input  vsrl_pkg::status_t status,
	output vsrl_pkg::ctrl_t   ctrl
);
	import vsrl_pkg::*;

	localparam int CNT_W = $clog2(DATA_WIDTH + GUARD_BITS + 1);

	step_t            step_q, step_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	ucode_t           word;

	assign word = ucode_rom(step_q);

	always_comb begin
		step_d = step_q + step_t'(1);
		cnt_d  = cnt_q;
		unique case (word.lc)
			LC_ROOT: cnt_d = CNT_W'(DATA_WIDTH + GUARD_BITS);
			LC_DIV:  cnt_d = CNT_W'(DATA_WIDTH);
			LC_NONE: cnt_d = cnt_q;
			default: cnt_d = cnt_q;
		endcase
		unique case (word.jc)
			JC_NONE: step_d = step_q + step_t'(1);
			JC_WAIT: begin
				if (!start)
					step_d = step_q;
			end
			JC_SKIP_CLEAR: begin
				if (!status.limited)
					step_d = word.target;
			end
			JC_LOOP: begin
				// stay on this step until the count runs out
				if (cnt_q != '0) begin
					step_d = step_q;
					cnt_d  = cnt_q - CNT_W'(1);
				end
			end
			JC_END: step_d = out_free ? ST_IDLE : step_q;
			default: step_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.op     = word.op;
		ctrl.commit = (word.jc == JC_END) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			cnt_q  <= '0;
		end else begin
			step_q <= step_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

// ===== design/vsrl_dp.sv =====
// ----------------------------------------------------------------------------
// Vector slew rate limiter datapath
// Difference, squares, bit-serial square root, two bit-serial dividers and
// the saturating move, each stepped by the sequencer's control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsrl_dp #(
	parameter int DATA_WIDTH = vsrl_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vsrl_pkg::ctrl_t       ctrl,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] in_x,
	input  logic [DATA_WIDTH-1:0] in_y,
	input  logic [DATA_WIDTH-1:0] step_limit,
	output vsrl_pkg::status_t     status,
	output logic [DATA_WIDTH-1:0] res_x,
	output logic [DATA_WIDTH-1:0] res_y,
	output logic                  res_limited
);
	import vsrl_pkg::*;

	localparam int W    = DATA_WIDTH;
	localparam int SW   = 2 * W + 1;
	localparam int RADW = 2 * W + 2 + 2 * GUARD_BITS;
	localparam int LW   = RADW / 2;
	localparam int RW   = LW + 3;
	localparam int NW   = 2 * W + GUARD_BITS;
	localparam int QW   = W + 1;

	logic [W-1:0]    last_q  [2];
	logic [W-1:0]    tgt_q   [2];
	logic            neg_q   [2];
	logic [W-1:0]    mag_q   [2];
	logic [2*W-1:0]  sq_q    [2];
	logic [2*W-1:0]  lim2_q;
	logic [RADW-1:0] rad_q;
	logic [RW-1:0]   rrem_q;
	logic [LW-1:0]   root_q;
	logic [LW-1:0]   drem_q  [2];
	logic [QW-1:0]   dbits_q [2];
	logic [QW-1:0]   quo_q   [2];

	logic [W:0]      diff_c  [2];
	logic [W:0]      magw_c  [2];
	logic [2*W-1:0]  prod_c  [2];
	logic [NW-1:0]   num_c   [2];
	logic [LW:0]     dn_c    [2];
	logic            dge_c   [2];
	logic            rnd_c   [2];
	logic [QW-1:0]   qr_c    [2];
	logic [W+1:0]    mv_c    [2];
	logic [W-1:0]    sat_c   [2];
	logic [W-1:0]    res_c   [2];
	logic [SW-1:0]   sum_c;
	logic [RW-1:0]   rn_c;
	logic [RW-1:0]   trial_c;

	assign sum_c          = {1'b0, sq_q[0]} + {1'b0, sq_q[1]};
	assign status.limited = sum_c > {1'b0, lim2_q};

	assign rn_c    = {rrem_q[RW-3:0], rad_q[RADW-1 -: 2]};
	assign trial_c = {1'b0, root_q, 2'b01};

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			diff_c[i] = {last_q[i][W-1], last_q[i]} - {tgt_q[i][W-1], tgt_q[i]};
			magw_c[i] = diff_c[i][W] ? (~diff_c[i] + (W+1)'(1)) : diff_c[i];
			prod_c[i] = step_limit * mag_q[i];
			num_c[i]  = {prod_c[i], {GUARD_BITS{1'b0}}};
			dn_c[i]   = {drem_q[i], dbits_q[i][QW-1]};
			dge_c[i]  = dn_c[i] >= {1'b0, root_q};
			// round to nearest, ties upward
			rnd_c[i]  = {drem_q[i], 1'b0} >= {1'b0, root_q};
			qr_c[i]   = quo_q[i] + QW'(rnd_c[i]);
			if (neg_q[i])
				mv_c[i] = {{2{last_q[i][W-1]}}, last_q[i]} + {1'b0, qr_c[i]};
			else
				mv_c[i] = {{2{last_q[i][W-1]}}, last_q[i]} - {1'b0, qr_c[i]};
			if (mv_c[i][W+1:W-1] == 3'b000 || mv_c[i][W+1:W-1] == 3'b111)
				sat_c[i] = mv_c[i][W-1:0];
			else if (mv_c[i][W+1])
				sat_c[i] = {1'b1, {(W-1){1'b0}}};
			else
				sat_c[i] = {1'b0, {(W-1){1'b1}}};
			res_c[i] = (ctrl.op == OP_MOVE) ? sat_c[i] : tgt_q[i];
		end
	end

	assign res_x       = res_c[0];
	assign res_y       = res_c[1];
	assign res_limited = (ctrl.op == OP_MOVE);

	// last position: every delivered word becomes the new reference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q[0] <= '0;
			last_q[1] <= '0;
		end else if (ctrl.commit) begin
			last_q[0] <= res_c[0];
			last_q[1] <= res_c[1];
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_IDLE: begin
				if (start) begin
					tgt_q[0] <= in_x;
					tgt_q[1] <= in_y;
				end
			end
			OP_DIFF: begin
				for (int i = 0; i < 2; i++) begin
					neg_q[i] <= diff_c[i][W];
					mag_q[i] <= magw_c[i][W-1:0];
				end
			end
			OP_SQUARE: begin
				for (int i = 0; i < 2; i++)
					sq_q[i] <= mag_q[i] * mag_q[i];
				lim2_q <= step_limit * step_limit;
			end
			OP_CMP: begin
				rad_q  <= {1'b0, sum_c, {(2*GUARD_BITS){1'b0}}};
				rrem_q <= '0;
				root_q <= '0;
			end
			OP_ROOT: begin
				// one result bit per step, two radicand bits in
				rad_q <= {rad_q[RADW-3:0], 2'b00};
				if (rn_c >= trial_c) begin
					rrem_q <= rn_c - trial_c;
					root_q <= {root_q[LW-2:0], 1'b1};
				end else begin
					rrem_q <= rn_c;
					root_q <= {root_q[LW-2:0], 1'b0};
				end
			end
			OP_PROD: begin
				// upper dividend bits are known to stay below the divisor
				for (int i = 0; i < 2; i++) begin
					drem_q[i]  <= LW'(num_c[i][NW-1:QW]);
					dbits_q[i] <= num_c[i][QW-1:0];
					quo_q[i]   <= '0;
				end
			end
			OP_DIV: begin
				for (int i = 0; i < 2; i++) begin
					dbits_q[i] <= {dbits_q[i][QW-2:0], 1'b0};
					if (dge_c[i]) begin
						drem_q[i] <= LW'(dn_c[i] - {1'b0, root_q});
						quo_q[i]  <= {quo_q[i][QW-2:0], 1'b1};
					end else begin
						drem_q[i] <= dn_c[i][LW-1:0];
						quo_q[i]  <= {quo_q[i][QW-2:0], 1'b0};
					end
				end
			end
			OP_MOVE, OP_PASS: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/vector_slew_rate_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// Vector slew rate limiter unit
// A limited word is loaded into the output register after the difference,
// square, compare, square root, product, divide and move steps; a word that
// passes is loaded after the difference, square, compare and pass steps. The
// input reopens once the word is loaded, so the unit takes no new word while
// one is in work. Square root and divide each resolve one bit per cycle; a
// full output register holds the last step. Reset clears the last position
// and sets step_limit to 8192.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_slew_rate_limiter_unit #(
	parameter int DATA_WIDTH = vsrl_pkg::DATA_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [DATA_WIDTH-1:0]                   cfg_data,      // step_limit
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,  // target_x, target_y
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]       m_axis_tdata,  // out_x, out_y
	output logic [0:0]                              m_axis_tuser   // was_limited
);
	import vsrl_pkg::*;

	localparam int TD_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

	logic [DATA_WIDTH-1:0] step_limit_q;
	logic [TD_W-1:0]       tdata_q;
	logic                  tuser_q;
	logic                  tvalid_q;
	logic                  start;
	logic                  out_free;
	ctrl_t                 ctrl;
	status_t               status;
	logic [DATA_WIDTH-1:0] res_x;
	logic [DATA_WIDTH-1:0] res_y;
	logic                  res_limited;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (ctrl.op == OP_IDLE);
	assign start         = s_axis_tvalid && s_axis_tready;
	assign out_free      = !tvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_limit_q <= DATA_WIDTH'(LIMIT_RESET);
		else if (cfg_valid && cfg_ready)
			step_limit_q <= cfg_data;
	end

	vsrl_seq #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.status   (status),
		.ctrl     (ctrl)
	);

	vsrl_dp #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.start       (start),
		.in_x        (s_axis_tdata[DATA_WIDTH-1:0]),
		.in_y        (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.step_limit  (step_limit_q),
		.status      (status),
		.res_x       (res_x),
		.res_y       (res_y),
		.res_limited (res_limited)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tvalid_q <= 1'b0;
		else if (ctrl.commit)
			tvalid_q <= 1'b1;
		else if (m_axis_tready)
			tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			tdata_q <= TD_W'({res_y, res_x});
			tuser_q <= res_limited;
		end
	end

	assign m_axis_tvalid   = tvalid_q;
	assign m_axis_tdata    = tdata_q;
	assign m_axis_tuser[0] = tuser_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a word is in work");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |=> m_axis_tvalid)
		else $error("committed word missing from output register");

	a_root_exit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_ROOT |=> ctrl.op == OP_ROOT || ctrl.op == OP_PROD)
		else $error("square root loop left to a wrong step");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |-> !tvalid_q || m_axis_tready)
		else $error("commit overwrote an undelivered word");
`endif

endmodule

// ===== tb/sv/vector_slew_rate_limiter_unit_test.sv =====
// ----------------------------------------------------------------------------
// Vector slew rate limiter unit test
// Drives target positions into the stream input and checks every output word
// against a bit-true position tracker kept in the bench. Directed cases cover
// the reset limit, the equal-length boundary, a zero limit and full scale;
// random sweeps then run several limits with random gaps on both sides and one
// long output stall that backs the unit up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_slew_rate_limiter_unit_test;

	localparam int W           = vsrl_pkg::DATA_WIDTH_DEF;
	localparam int TD_W        = ((2*W+7)/8)*8;
	localparam longint POS_MAX = (longint'(1) <<< (W-1)) - 1;
	localparam longint POS_MIN = -POS_MAX - 1;
	localparam longint LIM_MAX = (longint'(1) <<< W) - 1;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct {
		logic [W-1:0] x;
		logic [W-1:0] y;
		logic         limited;
	} move_t;

	logic            clk           = 1'b0;
	logic            arst_n        = 1'b0;
	logic            cfg_valid     = 1'b0;
	logic            cfg_ready;
	logic [W-1:0]    cfg_data      = '0;
	logic            s_axis_tvalid = 1'b0;
	logic            s_axis_tready;
	logic [TD_W-1:0] s_axis_tdata  = '0;   // target_x, target_y
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;
	logic [TD_W-1:0] m_axis_tdata;         // out_x, out_y
	logic [0:0]      m_axis_tuser;         // was_limited

	// tracked state of the unit
	longint pos_x        = 0;
	longint pos_y        = 0;
	longint step_limit_q = vsrl_pkg::LIMIT_RESET;

	move_t  moves_due[$];
	move_t  due_move;
	int     failures        = 0;
	int     cycle_count     = 0;
	int     hold_off_cycles = 0;
	bit     src_idle        = 1'b1;
	bit     sink_idle       = 1'b1;

	vector_slew_rate_limiter_unit #(
		.DATA_WIDTH(W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time, moves_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic longint clamp_q15(input longint v);
		if (v > POS_MAX) begin
			return POS_MAX;
		end
		if (v < POS_MIN) begin
			return POS_MIN;
		end
		return v;
	endfunction

	// floor of the square root, one result bit per pass
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned trial;
		rem  = 0;
		root = 0;
		for (int i = 31; i >= 0; i--) begin
			rem   = (rem << 2) | ((n >> (2*i)) & 64'd3);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	// len carries 8 extra fraction bits; round the step to nearest, ties up
	function automatic longint step_toward(input longint last, input longint d,
			input longint len);
		longint mag;
		longint num;
		longint q;
		mag = (d < 0) ? -d : d;
		num = (step_limit_q * mag) <<< vsrl_pkg::GUARD_BITS;
		q   = num / len;
		if (2 * (num % len) >= len) begin
			q++;
		end
		return clamp_q15((d < 0) ? last + q : last - q);
	endfunction

	function automatic move_t advance_position(input longint tx, input longint ty);
		longint dx;
		longint dy;
		longint dist_sq;
		longint len;
		move_t  m;
		dx        = pos_x - tx;
		dy        = pos_y - ty;
		dist_sq   = dx*dx + dy*dy;
		m.limited = (dist_sq > step_limit_q * step_limit_q);
		if (m.limited) begin
			len   = longint'(int_sqrt(longint'(dist_sq) << (2*vsrl_pkg::GUARD_BITS)));
			pos_x = step_toward(pos_x, dx, len);
			pos_y = step_toward(pos_y, dy, len);
		end else begin
			pos_x = tx;
			pos_y = ty;
		end
		m.x = pos_x[W-1:0];
		m.y = pos_y[W-1:0];
		return m;
	endfunction

	task automatic send_target(input longint tx, input longint ty);
		int     gap;
		longint cx;
		longint cy;
		cx  = clamp_q15(tx);
		cy  = clamp_q15(ty);
		gap = src_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {cy[W-1:0], cx[W-1:0]};
		do @(posedge clk); while (!s_axis_tready);
		moves_due.push_back(advance_position(cx, cy));
	endtask

	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		while (moves_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_step_limit(input longint value);
		wait_all_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value[W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		step_limit_q = value & LIM_MAX;
	endtask

	task automatic send_random_target();
		int     mode;
		longint span;
		mode = $urandom_range(0, 9);
		span = step_limit_q + step_limit_q / 2 + 2;
		case (mode)
			0, 1: begin
				send_target(longint'($urandom_range(0, LIM_MAX)) + POS_MIN,
					longint'($urandom_range(0, LIM_MAX)) + POS_MIN);
			end
			7: begin
				send_target(pos_x, pos_y);
			end
			8: begin
				// land exactly on the limit along one axis
				if ($urandom_range(0, 1)) begin
					send_target((pos_x + step_limit_q <= POS_MAX) ?
						pos_x + step_limit_q : pos_x - step_limit_q, pos_y);
				end else begin
					send_target(pos_x, (pos_y + step_limit_q <= POS_MAX) ?
						pos_y + step_limit_q : pos_y - step_limit_q);
				end
			end
			9: begin
				send_target($urandom_range(0, 1) ? POS_MAX : POS_MIN,
					$urandom_range(0, 1) ? POS_MAX : POS_MIN);
			end
			default: begin
				send_target(pos_x + longint'($urandom_range(0, 2*span)) - span,
					pos_y + longint'($urandom_range(0, 2*span)) - span);
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (moves_due.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h/%b", $time,
					m_axis_tdata, m_axis_tuser);
				failures++;
			end else begin
				due_move = moves_due.pop_front();
				if (m_axis_tdata[W-1:0] !== due_move.x) begin
					$display("%0t: out_x expected %h actual %h", $time, due_move.x,
						m_axis_tdata[W-1:0]);
					failures++;
				end
				if (m_axis_tdata[2*W-1:W] !== due_move.y) begin
					$display("%0t: out_y expected %h actual %h", $time, due_move.y,
						m_axis_tdata[2*W-1:W]);
					failures++;
				end
				if (m_axis_tuser[0] !== due_move.limited) begin
					$display("%0t: was_limited expected %b actual %b", $time,
						due_move.limited, m_axis_tuser[0]);
					failures++;
				end
			end
		end
	end

	initial begin : result_sink
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			gap = sink_idle ? $urandom_range(0, 15) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// reset limit of 0.25, starting from the origin
	task automatic test_reset_defaults();
		send_target(0, 0);
		send_target(8192, 0);
		send_target(8192, 8192 + 8193);
		send_target(POS_MIN, POS_MIN);
		send_target(POS_MAX, POS_MAX);
	endtask

	task automatic test_equal_length();
		write_step_limit(LIM_MAX);
		send_target(0, 0);
		write_step_limit(5000);
		send_target(3000, 4000);
		send_target(6000, 8001);
		send_target(pos_x - 4000, pos_y - 3000);
		send_target(pos_x - 4001, pos_y - 3000);
	endtask

	// zero limit: hold on any change, pass only an unchanged position
	task automatic test_zero_limit();
		write_step_limit(0);
		send_target(pos_x, pos_y);
		send_target(pos_x + 1, pos_y);
		send_target(POS_MIN, POS_MAX);
		send_target(POS_MAX, POS_MIN);
	endtask

	task automatic test_full_scale();
		write_step_limit(LIM_MAX);
		send_target(POS_MIN, POS_MIN);
		send_target(POS_MAX, POS_MAX);
		send_target(POS_MAX, POS_MIN);
		send_target(POS_MIN, POS_MAX);
		send_target(POS_MIN, 0);
		send_target(POS_MAX, 0);
		write_step_limit(1);
		send_target(POS_MIN, POS_MIN);
		send_target(pos_x + 1, pos_y);
	endtask

	task automatic test_random_sweep();
		longint limits[8];
		limits = '{8192, 0, 0, LIM_MAX, 1, 0, 32768, 0};
		limits[1] = $urandom_range(0, LIM_MAX);
		limits[2] = 0;
		limits[5] = $urandom_range(0, 2000);
		limits[7] = $urandom_range(0, LIM_MAX);
		for (int p = 0; p < 8; p++) begin
			write_step_limit(limits[p]);
			src_idle  = (p % 4 == 0) || (p % 4 == 2);
			sink_idle = (p % 4 == 0) || (p % 4 == 3);
			repeat (110) send_random_target();
		end
	endtask

	// stall the output long enough that the input side backs up
	task automatic test_backpressure();
		write_step_limit(8192);
		src_idle        = 1'b0;
		sink_idle       = 1'b1;
		hold_off_cycles = 400;
		repeat (30) send_random_target();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_equal_length();
		test_zero_limit();
		test_full_scale();
		test_random_sweep();
		test_backpressure();
		wait_all_results();
		repeat (60) @(posedge clk);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/vsrl_pkg.sv
design/vsrl_seq.sv
design/vsrl_dp.sv
design/vector_slew_rate_limiter_unit.sv
tb/sv/vector_slew_rate_limiter_unit_test.sv
